[hw/rtl/bgms_pkg.sv]
`default_nettype none

package bgms_pkg;

    // Default geometry of the scanner.
    localparam int PROMOTER_LEN_DEF   = 22;
    localparam int STEM_LEN_DEF       = 4;
    localparam int TERMINATOR_LEN_DEF = 11;
    localparam int SITE_LEN_DEF       = 6;
    localparam int SPACER_LEN_DEF     = 4;
    localparam int CODON_LEN_DEF      = 3;

    // Fixed result field widths.
    localparam int POSITION_W = 20;
    localparam int PROM_MM_W  = 5;
    localparam int TERM_MM_W  = 3;
    localparam int CODON_W    = 3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROMOTER_MOTIF   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SITE_MOTIF = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CODON      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_CODON       = 2'd3;

    typedef struct packed {
        logic base;
        logic restart;
    } item_t;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic [PROM_MM_W-1:0]  promoter_mismatches;
        logic [TERM_MM_W-1:0]  terminator_mismatches;
        logic                  start_site_found;
        logic                  stop_found;
        logic [CODON_W-1:0]    codon_value;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/binary_genome_motif_scanner_core.sv]
// Channel   Signals                               Direction  Transfer when
// item      item_valid, item_ready, item          in         item_valid && item_ready
// result    result_valid, result_ready, result    out        result_valid && result_ready
// cfg       cfg_we, cfg_index, cfg_data           in         cfg_we
//
// One base is taken every cycle while item_ready is high; its result, if any, is
// registered into the output register, or into the skid stage when the output
// register holds a result not yet taken. The window register shifts once per transfer.
// Reset clears the window, fill count, position, configuration and the valid flags of
// both output register stages. A stall on the result side is absorbed by a skid
// stage, so item_ready drops only when both stages hold results.
`default_nettype none

module binary_genome_motif_scanner_core
    import bgms_pkg::*;
#(
    parameter int PROMOTER_LEN   = PROMOTER_LEN_DEF,
    parameter int STEM_LEN       = STEM_LEN_DEF,
    parameter int TERMINATOR_LEN = TERMINATOR_LEN_DEF,
    parameter int SITE_LEN       = SITE_LEN_DEF,
    parameter int SPACER_LEN     = SPACER_LEN_DEF,
    parameter int CODON_LEN      = CODON_LEN_DEF,
    localparam int CFG_W = (PROMOTER_LEN >= SITE_LEN && PROMOTER_LEN >= CODON_LEN)
                           ? PROMOTER_LEN : ((SITE_LEN >= CODON_LEN) ? SITE_LEN : CODON_LEN)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire item_t                  item,

    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_t                     result,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int FILL_W = $clog2(PROMOTER_LEN + 1);
    localparam int PCNT_W = $clog2(PROMOTER_LEN + 1);
    localparam int TCNT_W = $clog2(STEM_LEN + 1);
    localparam int CODON_POS = SITE_LEN + SPACER_LEN;

    logic [PROMOTER_LEN-1:0] promoter_motif_reg;
    logic [SITE_LEN-1:0]     start_site_motif_reg;
    logic [CODON_LEN-1:0]    start_codon_reg;
    logic [CODON_LEN-1:0]    stop_codon_reg;

    logic [PROMOTER_LEN-1:0] window_reg, window_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [POSITION_W-1:0]   position_reg, position_next;
    logic                    produce;

    result_t                 out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 skid_reg, skid_next;
    logic                    skid_valid_reg, skid_valid_next;

    result_t                 fresh;
    logic                    item_xfer;
    logic                    push;
    logic                    pop;

    logic [PCNT_W-1:0]       prom_cnt;
    logic [TCNT_W-1:0]       term_cnt;
    logic [SITE_LEN-1:0]     site_field;
    logic [CODON_LEN-1:0]    start_field;
    logic [CODON_LEN-1:0]    codon_field;

    // Base k of a window, base 0 being the oldest; bases past the end read 0.
    function automatic logic wbase(input logic [PROMOTER_LEN-1:0] w, input int k);
        if (k >= PROMOTER_LEN)
        begin
            return 1'b0;
        end
        return w[PROMOTER_LEN-1-k];
    endfunction

    assign item_xfer    = item_valid && item_ready;
    assign item_ready   = !skid_valid_reg;
    assign pop          = out_valid_reg && result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promoter_motif_reg   <= '0;
            start_site_motif_reg <= '0;
            start_codon_reg      <= '0;
            stop_codon_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PROMOTER_MOTIF:   promoter_motif_reg   <= cfg_data[PROMOTER_LEN-1:0];
                CFG_START_SITE_MOTIF: start_site_motif_reg <= cfg_data[SITE_LEN-1:0];
                CFG_START_CODON:      start_codon_reg      <= cfg_data[CODON_LEN-1:0];
                CFG_STOP_CODON:       stop_codon_reg       <= cfg_data[CODON_LEN-1:0];
                default:              ;
            endcase
        end
    end

    // Window, fill and position update for the incoming base.
    always_comb
    begin
        logic [PROMOTER_LEN-1:0] w;
        logic [FILL_W-1:0]       f;
        logic [POSITION_W-1:0]   p;
        w = window_reg;
        f = fill_reg;
        p = position_reg;
        if (item.restart)
        begin
            w = '0;
            f = '0;
            p = '0;
        end
        window_next = {w[PROMOTER_LEN-2:0], item.base};
        if (f < FILL_W'(PROMOTER_LEN))
        begin
            fill_next = f + 1'b1;
            produce   = (fill_next == FILL_W'(PROMOTER_LEN));
        end
        else
        begin
            fill_next = f;
            p         = p + 1'b1;
            produce   = 1'b1;
        end
        position_next = p;
    end

    // Match logic on the shifted window.
    always_comb
    begin
        prom_cnt = '0;
        for (int i = 0; i < PROMOTER_LEN; i++)
        begin
            prom_cnt = prom_cnt + PCNT_W'(window_next[i] ^ promoter_motif_reg[i]);
        end

        // A stem pair counts when its two bases are equal.
        term_cnt = '0;
        for (int i = 0; i < STEM_LEN; i++)
        begin
            if (i <= TERMINATOR_LEN - 1)
            begin
                term_cnt = term_cnt
                         + TCNT_W'(wbase(window_next, i) == wbase(window_next, TERMINATOR_LEN-1-i));
            end
            else
            begin
                term_cnt = term_cnt + TCNT_W'(wbase(window_next, i) == 1'b0);
            end
        end

        for (int i = 0; i < SITE_LEN; i++)
        begin
            site_field[SITE_LEN-1-i] = wbase(window_next, i);
        end
        for (int i = 0; i < CODON_LEN; i++)
        begin
            start_field[CODON_LEN-1-i] = wbase(window_next, CODON_POS + i);
            codon_field[CODON_LEN-1-i] = wbase(window_next, i);
        end

        fresh.position              = position_next;
        fresh.promoter_mismatches   = PROM_MM_W'(prom_cnt);
        fresh.terminator_mismatches = TERM_MM_W'(term_cnt);
        fresh.start_site_found      = (site_field == start_site_motif_reg)
                                      && (start_field == start_codon_reg);
        fresh.stop_found            = (codon_field == stop_codon_reg);
        fresh.codon_value           = CODON_W'(codon_field);
    end

    assign push = item_xfer && produce;

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = fresh;
                skid_valid_next = push;
            end
            else
            begin
                out_next       = fresh;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = fresh;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            fill_reg       <= '0;
            position_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_xfer)
            begin
                window_reg   <= window_next;
                fill_reg     <= fill_next;
                position_reg <= position_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

[hw/rtl/bgms_checker.sv]
`default_nettype none

module bgms_checker
    import bgms_pkg::*;
#(
    parameter int PROMOTER_LEN = PROMOTER_LEN_DEF,
    parameter int STEM_LEN     = STEM_LEN_DEF
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    // Once reset has been seen at a clock edge, no result can be pending.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result_valid high during reset");

    // The input side only backs up when the output side holds a result.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("item_ready low with no result pending");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result dropped or changed");

    // Mismatch counts cannot exceed the number of bases compared.
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(result.promoter_mismatches) <= PROMOTER_LEN)
                      && (int'(result.terminator_mismatches) <= STEM_LEN))
        else $error("mismatch count out of range");

endmodule

bind binary_genome_motif_scanner_core bgms_checker #(
    .PROMOTER_LEN (PROMOTER_LEN),
    .STEM_LEN     (STEM_LEN)
) u_bgms_checker (.*);

`default_nettype wire

[verif/binary_genome_motif_scanner_core_tb.sv]
`timescale 1ns / 100ps

module binary_genome_motif_scanner_core_tb;
    import bgms_pkg::*;

    localparam int PLEN = PROMOTER_LEN_DEF;
    localparam int STEM = STEM_LEN_DEF;
    localparam int TLEN = TERMINATOR_LEN_DEF;
    localparam int SLEN = SITE_LEN_DEF;
    localparam int GAP  = SPACER_LEN_DEF;
    localparam int CLEN = CODON_LEN_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_ready;
    item_t            item = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;
    logic             cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_PROMOTER_MOTIF;
    logic [PLEN-1:0]  cfg_data = '0;

    // Scanner state as the testbench sees it.
    logic [PLEN-1:0]       promoter_reg = '0;
    logic [SLEN-1:0]       site_reg = '0;
    logic [CLEN-1:0]       start_reg = '0;
    logic [CLEN-1:0]       stop_reg = '0;
    logic [PLEN-1:0]       scan_window = '0;
    int                    scan_fill = 0;
    logic [POSITION_W-1:0] scan_pos = '0;

    item_t   genome_feed[$];
    result_t expected_reports[$];

    int  fail_count = 0;
    int  shown_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;

    binary_genome_motif_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Shifts one base into the window and returns 1 when the window start
    // has a report.
    function automatic bit scan_base(input item_t it, output result_t rep);
        int prom;
        int term;
        logic [CLEN-1:0] codon;
        rep = '0;
        if (it.restart)
        begin
            scan_window = '0;
            scan_fill = 0;
            scan_pos = '0;
        end
        scan_window = {scan_window[PLEN-2:0], it.base};
        if (scan_fill < PLEN)
        begin
            scan_fill++;
            if (scan_fill < PLEN)
                return 1'b0;
        end
        else
        begin
            scan_pos = scan_pos + 1'b1;
        end
        prom = $countones(scan_window ^ promoter_reg);
        term = 0;
        // Window base k sits at bit PLEN-1-k.
        for (int i = 0; i < STEM; i++)
        begin
            if (scan_window[PLEN-1-i] == scan_window[PLEN-1-(TLEN-1-i)])
                term++;
        end
        codon = scan_window[PLEN-1 -: CLEN];
        rep.position = scan_pos;
        rep.promoter_mismatches = prom[PROM_MM_W-1:0];
        rep.terminator_mismatches = term[TERM_MM_W-1:0];
        rep.start_site_found = (scan_window[PLEN-1 -: SLEN] == site_reg) &&
                               (scan_window[PLEN-1-SLEN-GAP -: CLEN] == start_reg);
        rep.stop_found = (codon == stop_reg);
        rep.codon_value = codon;
        return 1'b1;
    endfunction

    // Mostly back-to-back, some short pauses and a few long ones; no pauses while steady is set.
    function automatic int pick_delay(input int longest);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, longest);
    endfunction

    task automatic check_report(input result_t got);
        result_t want;
        if (expected_reports.size() == 0)
        begin
            fail_count++;
            if (shown_count < 10)
                $display("unexpected result: pos=%0d prom=%0d term=%0d site=%0b stop=%0b codon=%0d",
                         got.position, got.promoter_mismatches, got.terminator_mismatches,
                         got.start_site_found, got.stop_found, got.codon_value);
            shown_count++;
        end
        else
        begin
            want = expected_reports.pop_front();
            if (got.position !== want.position ||
                got.promoter_mismatches !== want.promoter_mismatches ||
                got.terminator_mismatches !== want.terminator_mismatches ||
                got.start_site_found !== want.start_site_found ||
                got.stop_found !== want.stop_found ||
                got.codon_value !== want.codon_value)
            begin
                fail_count++;
                if (shown_count < 10)
                begin
                    $display("mismatch: expected pos=%0d prom=%0d term=%0d site=%0b stop=%0b codon=%0d",
                             want.position, want.promoter_mismatches,
                             want.terminator_mismatches, want.start_site_found,
                             want.stop_found, want.codon_value);
                    $display("          actual   pos=%0d prom=%0d term=%0d site=%0b stop=%0b codon=%0d",
                             got.position, got.promoter_mismatches,
                             got.terminator_mismatches, got.start_site_found,
                             got.stop_found, got.codon_value);
                end
                shown_count++;
            end
        end
    endtask

    // Item driver.
    always @(posedge clk or negedge rst_n)
    begin : feed_driver
        result_t rep;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                if (scan_base(item, rep))
                    expected_reports.push_back(rep);
                gap_left = pick_delay(30);
            end
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (genome_feed.size() > 0)
                begin
                    item <= genome_feed.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                check_report(result);
                stall_left = pick_delay(40);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("binary_genome_motif_scanner_core_tb failed");
                $finish;
            end
        end
    end

    task automatic push_base(input logic b, input logic r);
        item_t it;
        it.base = b;
        it.restart = r;
        genome_feed.push_back(it);
    endtask

    task automatic wait_idle();
        while (genome_feed.size() != 0 || item_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PLEN-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_PROMOTER_MOTIF:   promoter_reg = val;
            CFG_START_SITE_MOTIF: site_reg = val[SLEN-1:0];
            CFG_START_CODON:      start_reg = val[CLEN-1:0];
            CFG_STOP_CODON:       stop_reg = val[CLEN-1:0];
            default: ;
        endcase
    endtask

    // Narrow registers get random junk above their width, which must be dropped.
    task automatic load_config(input logic [PLEN-1:0] prom, input logic [SLEN-1:0] site,
                               input logic [CLEN-1:0] start, input logic [CLEN-1:0] stop);
        logic [PLEN-1:0] junk;
        junk = PLEN'($urandom());
        write_reg(CFG_PROMOTER_MOTIF, prom);
        write_reg(CFG_START_SITE_MOTIF, {junk[PLEN-1:SLEN], site});
        junk = PLEN'($urandom());
        write_reg(CFG_START_CODON, {junk[PLEN-1:CLEN], start});
        junk = PLEN'($urandom());
        write_reg(CFG_STOP_CODON, {junk[PLEN-1:CLEN], stop});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One genome, usually opened by a restart, often carrying planted motifs
    // and sometimes closed circularly with its first PLEN-1 bases.
    task automatic queue_genome(output int added);
        bit g[$];
        int len;
        int o;
        int k;
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(1, PLEN - 1);
        else
            len = $urandom_range(PLEN, 64);
        for (k = 0; k < len; k++)
            g.push_back(1'($urandom_range(0, 1)));
        if (len >= SLEN + GAP + CLEN && $urandom_range(0, 2) == 0)
        begin
            o = $urandom_range(0, len - (SLEN + GAP + CLEN));
            for (k = 0; k < SLEN; k++)
                g[o+k] = site_reg[SLEN-1-k];
            for (k = 0; k < CLEN; k++)
                g[o+SLEN+GAP+k] = start_reg[CLEN-1-k];
        end
        if (len >= PLEN && $urandom_range(0, 3) == 0)
        begin
            o = $urandom_range(0, len - PLEN);
            for (k = 0; k < PLEN; k++)
                g[o+k] = promoter_reg[PLEN-1-k];
            repeat ($urandom_range(0, 3))
            begin
                k = $urandom_range(0, PLEN - 1);
                g[o+k] = ~g[o+k];
            end
        end
        if (len >= CLEN && $urandom_range(0, 2) == 0)
        begin
            o = $urandom_range(0, len - CLEN);
            for (k = 0; k < CLEN; k++)
                g[o+k] = stop_reg[CLEN-1-k];
        end
        if (len >= PLEN && $urandom_range(0, 1) == 1)
        begin
            for (k = 0; k < PLEN - 1; k++)
                g.push_back(g[k]);
        end
        for (k = 0; k < g.size(); k++)
        begin
            if (k == 0)
                push_base(g[k], $urandom_range(0, 9) != 0);
            else
                push_base(g[k], $urandom_range(0, 199) == 0);
        end
        added = g.size();
    endtask

    initial
    begin : stimulus
        int n;
        int added;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: an all-zero genome matches every pattern.
        for (n = 0; n < PLEN; n++)
            push_base(1'b0, 1'b0);
        wait_idle();
        // All-ones patterns against a window that still holds zeros, then a
        // restart that lands on a full window.
        load_config('1, '1, '1, '1);
        push_base(1'b1, 1'b0);
        push_base(1'b1, 1'b0);
        push_base(1'b1, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            steady = (ph == 4);
            case (ph)
                0:       load_config('0, '0, '0, '0);
                1:       load_config('1, '1, '1, '1);
                7:       load_config(22'h2AAAAA, '0, '1, '0);
                default: load_config(PLEN'($urandom()), SLEN'($urandom()),
                                     CLEN'($urandom()), CLEN'($urandom()));
            endcase
            n = 0;
            while (n < 75)
            begin
                queue_genome(added);
                n += added;
            end
        end
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_reports.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("binary_genome_motif_scanner_core_tb passed");
        else
            $display("binary_genome_motif_scanner_core_tb failed");
        $finish;
    end

endmodule
